// ===== rtl/tktic_pkg.sv =====
// shared types and codes for the two-key tap interval capture block
package tktic_pkg;

    // operation codes
    localparam logic [2:0] OP_BEGIN   = 3'd0;
    localparam logic [2:0] OP_DOWN    = 3'd1;
    localparam logic [2:0] OP_UP      = 3'd2;
    localparam logic [2:0] OP_FINISH  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_PREVIEW = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_A        = 2'd0;
    localparam logic [1:0] REG_KEY_B        = 2'd1;
    localparam logic [1:0] REG_WINDOW_START = 2'd2;
    localparam logic [1:0] REG_WINDOW_END   = 2'd3;

    typedef struct packed {
        logic [15:0]        key_a;
        logic [15:0]        key_b;
        logic signed [31:0] window_start;
        logic signed [31:0] window_end;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [15:0]        key_code;
        logic signed [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic               capturing;
        logic               held_first;
        logic               held_second;
        logic               owner_valid;
        logic               owner_second;
        logic               any_block;
        logic signed [31:0] gap_from;
        logic signed [31:0] open_from;
        logic signed [31:0] last_block_end;
    } state_t;

    typedef struct packed {
        logic               accepted;
        logic               block_valid;
        logic signed [31:0] block_start;
        logic signed [31:0] block_end;
        logic               block_is_gap;
    } result_t;

endpackage

// ===== rtl/tktic_item_if.sv =====
// input event channel
interface tktic_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [15:0]        key_code;
    logic signed [31:0] time_ms;

    modport source (output valid, output op, output key_code, output time_ms, input ready);
    modport sink (input valid, input op, input key_code, input time_ms, output ready);
endinterface

// ===== rtl/tktic_result_if.sv =====
// result channel
interface tktic_result_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               block_valid;
    logic signed [31:0] block_start;
    logic signed [31:0] block_end;
    logic               block_is_gap;

    modport source (output valid, output accepted, output block_valid, output block_start,
                    output block_end, output block_is_gap, input ready);
    modport sink (input valid, input accepted, input block_valid, input block_start,
                  input block_end, input block_is_gap, output ready);
endinterface

// ===== rtl/tktic_cfg_if.sv =====
// configuration write channel
interface tktic_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tktic_cfg_regs.sv =====
// configuration register file
module tktic_cfg_regs
    import tktic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_KEY_A:        cfg_reg.key_a        <= wr_data[15:0];
                REG_KEY_B:        cfg_reg.key_b        <= wr_data[15:0];
                REG_WINDOW_START: cfg_reg.window_start <= $signed(wr_data);
                REG_WINDOW_END:   cfg_reg.window_end   <= $signed(wr_data);
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tktic_step.sv =====
// next-state and result logic for one event
module tktic_step
    import tktic_pkg::*;
(
    input  item_t   item,
    input  cfg_t    cfg,
    input  state_t  cur,
    output state_t  nxt,
    output result_t res
);

    logic signed [31:0] win_end;
    logic               key_match;
    logic               second;
    logic               held_sel;
    logic signed [31:0] fin_raw;
    logic signed [31:0] fin_hi;
    logic signed [31:0] fin_t;
    logic signed [31:0] fin_e;
    logic signed [31:0] clip_hi;
    logic signed [31:0] clip_e;
    logic               fin_do;

    // window end and key decode
    assign win_end   = (cfg.window_end > cfg.window_start) ? cfg.window_end : cfg.window_start;
    assign key_match = (item.key_code == cfg.key_a) || (item.key_code == cfg.key_b);
    assign second    = (item.key_code != cfg.key_a);
    assign held_sel  = second ? cur.held_second : cur.held_first;

    // finish time, clamped into the window
    assign fin_raw = (item.op == OP_DOWN) ? cur.last_block_end : item.time_ms;
    assign fin_hi  = (fin_raw > win_end) ? win_end : fin_raw;
    assign fin_t   = (fin_hi < cfg.window_start) ? cfg.window_start : fin_hi;
    assign fin_e   = (fin_t > cur.open_from) ? fin_t : cur.open_from;

    // release or preview end, clamped to window end and open start
    assign clip_hi = (item.time_ms < win_end) ? item.time_ms : win_end;
    assign clip_e  = (clip_hi < cur.open_from) ? cur.open_from : clip_hi;

    always_comb
    begin
        nxt          = cur;
        res          = '0;
        res.accepted = 1'b1;
        fin_do       = 1'b0;

        case (item.op)
            OP_BEGIN:
            begin
                nxt.any_block    = 1'b0;
                nxt.held_first   = 1'b0;
                nxt.held_second  = 1'b0;
                nxt.owner_valid  = 1'b0;
                nxt.owner_second = 1'b0;
                nxt.gap_from     = cfg.window_start;
                nxt.capturing    = 1'b1;
            end
            OP_DOWN:
            begin
                if (!cur.capturing || !key_match || (item.time_ms < cfg.window_start) ||
                    (item.time_ms >= win_end) || held_sel)
                begin
                    res.accepted = 1'b0;
                end
                else if (cur.any_block && (item.time_ms < cur.last_block_end))
                begin
                    // press before the last block end forces finish
                    fin_do       = 1'b1;
                    res.accepted = 1'b0;
                end
                else
                begin
                    if (cur.owner_valid)
                    begin
                        res.block_valid = 1'b1;
                        res.block_start = cur.open_from;
                        res.block_end   = item.time_ms;
                    end
                    else if (item.time_ms > cur.gap_from)
                    begin
                        res.block_valid  = 1'b1;
                        res.block_start  = cur.gap_from;
                        res.block_end    = item.time_ms;
                        res.block_is_gap = 1'b1;
                    end
                    if (second)
                    begin
                        nxt.held_second = 1'b1;
                    end
                    else
                    begin
                        nxt.held_first = 1'b1;
                    end
                    nxt.owner_valid    = 1'b1;
                    nxt.owner_second   = second;
                    nxt.open_from      = item.time_ms;
                    nxt.last_block_end = item.time_ms;
                    nxt.any_block      = 1'b1;
                end
            end
            OP_UP:
            begin
                if (!key_match)
                begin
                    res.accepted = 1'b0;
                end
                else
                begin
                    if (second)
                    begin
                        nxt.held_second = 1'b0;
                    end
                    else
                    begin
                        nxt.held_first = 1'b0;
                    end
                    if (!cur.owner_valid || (cur.owner_second != second))
                    begin
                        res.accepted = held_sel;
                    end
                    else
                    begin
                        res.block_valid    = 1'b1;
                        res.block_start    = cur.open_from;
                        res.block_end      = clip_e;
                        nxt.gap_from       = clip_e;
                        nxt.last_block_end = clip_e;
                        nxt.owner_valid    = 1'b0;
                        nxt.owner_second   = 1'b0;
                    end
                end
            end
            OP_FINISH:
            begin
                fin_do = 1'b1;
            end
            OP_CLEAR:
            begin
                nxt.any_block    = 1'b0;
                nxt.held_first   = 1'b0;
                nxt.held_second  = 1'b0;
                nxt.owner_valid  = 1'b0;
                nxt.owner_second = 1'b0;
                nxt.capturing    = 1'b0;
            end
            OP_PREVIEW:
            begin
                if (cur.owner_valid)
                begin
                    res.block_valid = 1'b1;
                    res.block_start = cur.open_from;
                    res.block_end   = clip_e;
                end
            end
            default:
            begin
                res.accepted = 1'b0;
            end
        endcase

        // finish: close open block or trailing gap, then stop capture
        if (fin_do)
        begin
            if (cur.owner_valid)
            begin
                res.block_valid    = 1'b1;
                res.block_start    = cur.open_from;
                res.block_end      = fin_e;
                res.block_is_gap   = 1'b0;
                nxt.gap_from       = fin_e;
                nxt.last_block_end = fin_e;
            end
            else if (cur.capturing && cur.any_block && (fin_t > cur.gap_from))
            begin
                res.block_valid    = 1'b1;
                res.block_start    = cur.gap_from;
                res.block_end      = fin_t;
                res.block_is_gap   = 1'b1;
                nxt.gap_from       = fin_t;
                nxt.last_block_end = fin_t;
            end
            nxt.owner_valid  = 1'b0;
            nxt.owner_second = 1'b0;
            nxt.held_first   = 1'b0;
            nxt.held_second  = 1'b0;
            nxt.capturing    = 1'b0;
        end
    end

endmodule

// ===== rtl/two_key_tap_interval_capture.sv =====
// Result: a result word is registered when its event word is accepted.
// Throughput: one event per cycle; the state registers close a loop
// through the next-state logic, and a waiting result stalls input only when not taken.
// Reset: rst_n clears capture state, configuration and the result valid flag at once.
// Configuration writes are taken every cycle.
module two_key_tap_interval_capture
    import tktic_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    tktic_item_if.sink     item,
    tktic_result_if.source result,
    tktic_cfg_if.sink      cfg
);

    cfg_t    cfg_cur;
    item_t   item_word;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    take;

    // configuration registers
    assign cfg.ready = 1'b1;

    tktic_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    // input handshake
    assign item.ready = !out_valid_reg || result.ready;
    assign take       = item.valid && item.ready;

    assign item_word.op       = item.op;
    assign item_word.key_code = item.key_code;
    assign item_word.time_ms  = item.time_ms;

    // event logic
    tktic_step u_step (
        .item (item_word),
        .cfg  (cfg_cur),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = res_reg.accepted;
    assign result.block_valid  = res_reg.block_valid;
    assign result.block_start  = res_reg.block_start;
    assign result.block_end    = res_reg.block_end;
    assign result.block_is_gap = res_reg.block_is_gap;

`ifndef SYNTHESIS
    // an accepted event always yields a result word next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("accepted event produced no result");

    // an open block belongs to a held key
    a_owner_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.owner_valid |->
            ((state_reg.owner_second && state_reg.held_second) ||
             (!state_reg.owner_second && state_reg.held_first)))
        else $error("open block without its key held");

    // an open block only exists while capturing
    a_owner_capturing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.owner_valid |-> state_reg.capturing)
        else $error("open block outside capture");

    // empty results carry zero interval fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.block_valid) |->
            (res_reg.block_start == 0 && res_reg.block_end == 0 && !res_reg.block_is_gap))
        else $error("empty result carries interval data");
`endif

endmodule
